// ===== hw/rtl/fptdt_pkg.sv =====
// Package: sizes, character codes, state codes and control structs for the decimal text converter.
package fptdt_pkg;

  localparam int INT_BITS    = 8;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_DIGITS = 4;
  localparam int VAL_W       = INT_BITS + FRAC_BITS + 1;
  localparam int MAG_W       = INT_BITS + FRAC_BITS;

  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int n;
    v = (longint'(1) << bits) - 1;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int INT_DIGITS = dec_digits(INT_BITS);
  localparam int BCD_W      = INT_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(INT_BITS + 1);
  localparam int DIG_CNT_W  = $clog2(INT_DIGITS + 1);
  localparam int FD_CNT_W   = $clog2(FRAC_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_DOT   = 8'd46;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_DABBLE = 3'd1;
  localparam logic [STATE_W-1:0] ST_SIGN   = 3'd2;
  localparam logic [STATE_W-1:0] ST_INT    = 3'd3;
  localparam logic [STATE_W-1:0] ST_DOT    = 3'd4;
  localparam logic [STATE_W-1:0] ST_FRAC   = 3'd5;

  typedef struct packed {
    logic load;
    logic step;
    logic shift_out;
  } dabble_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } frac_ctrl_t;

endpackage

// ===== hw/rtl/fptdt_dabble.sv =====
// Bit-serial binary to BCD converter for the integer part, with digit shift-out.
module fptdt_dabble
  import fptdt_pkg::*;
(
  input  logic                clk,
  input  dabble_ctrl_t        ctrl,
  input  logic [INT_BITS-1:0] ipart,
  output logic [3:0]          top_digit
);

  logic [INT_BITS-1:0] bin;
  logic [BCD_W-1:0]    bcd;
  logic [BCD_W-1:0]    bcd_adj;

  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= ipart;
      bcd <= '0;
    end else if (ctrl.step) begin
      bin <= bin << 1;
      bcd <= {bcd_adj[BCD_W-2:0], bin[INT_BITS-1]};
    end else if (ctrl.shift_out) begin
      bcd <= bcd << 4;
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

endmodule

// ===== hw/rtl/fptdt_frac.sv =====
// Fraction digit generator: multiplies the fraction by ten once per digit.
module fptdt_frac
  import fptdt_pkg::*;
(
  input  logic                 clk,
  input  frac_ctrl_t           ctrl,
  input  logic [FRAC_BITS-1:0] frac_in,
  output logic [3:0]           digit
);

  localparam int PROD_W = FRAC_BITS + 4;

  logic [FRAC_BITS-1:0] frac;
  logic [PROD_W-1:0]    prod;

  assign prod  = (PROD_W'(frac) << 3) + (PROD_W'(frac) << 1);
  assign digit = prod[PROD_W-1 -: 4];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      frac <= frac_in;
    end else if (ctrl.step) begin
      frac <= prod[FRAC_BITS-1:0];
    end
  end

endmodule

// ===== hw/rtl/fixed_point_to_decimal_text.sv =====
// Top level: signed fixed-point value in, decimal ASCII text out, one character per transaction.
// The first character follows the bit-serial conversion of the integer part, and is delayed further
// for each skipped leading integer zero.
// A new value is taken only when the sequencer is back in idle, after the last fraction digit is emitted;
// the pace is set by the bit-serial BCD conversion and the one-digit-per-cycle emitter, when not stalled.
// Reset: synchronous, active high; clears the sequencer and the output valid, no characters pending.
module fixed_point_to_decimal_text
  import fptdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             value_valid,
  output logic             value_stall,
  input  logic [VAL_W-1:0] value_q16,
  output logic             char_valid,
  input  logic             char_stall,
  output logic [7:0]       char_code,
  output logic             last
);

  logic [STATE_W-1:0]   state, state_next;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [DIG_CNT_W-1:0] dig_cnt, dig_cnt_next;
  logic [FD_CNT_W-1:0]  fd_cnt, fd_cnt_next;
  logic                 started, started_next;
  logic                 neg;
  logic                 out_ready;
  logic                 emit;
  logic [7:0]           emit_code;
  logic                 emit_last;
  logic [VAL_W-1:0]     neg_val;
  logic [MAG_W-1:0]     mag;
  logic [3:0]           int_digit;
  logic [3:0]           frac_digit;
  dabble_ctrl_t         dab_ctrl;
  frac_ctrl_t           frac_ctrl;

  assign neg_val = -value_q16;

  always_comb begin
    if (!value_q16[VAL_W-1]) begin
      mag = value_q16[MAG_W-1:0];
    end else if (neg_val[VAL_W-1]) begin
      mag = '1;
    end else begin
      mag = neg_val[MAG_W-1:0];
    end
  end

  assign value_stall = (state != ST_IDLE);
  assign out_ready   = !char_valid || !char_stall;

  fptdt_dabble u_dabble (
    .clk       (clk),
    .ctrl      (dab_ctrl),
    .ipart     (mag[MAG_W-1 -: INT_BITS]),
    .top_digit (int_digit)
  );

  fptdt_frac u_frac (
    .clk     (clk),
    .ctrl    (frac_ctrl),
    .frac_in (mag[FRAC_BITS-1:0]),
    .digit   (frac_digit)
  );

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    dig_cnt_next = dig_cnt;
    fd_cnt_next  = fd_cnt;
    started_next = started;
    dab_ctrl     = '0;
    frac_ctrl    = '0;
    emit         = 1'b0;
    emit_code    = CHAR_ZERO;
    emit_last    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (value_valid) begin
          dab_ctrl.load  = 1'b1;
          frac_ctrl.load = 1'b1;
          bit_cnt_next   = BIT_CNT_W'(INT_BITS);
          dig_cnt_next   = DIG_CNT_W'(INT_DIGITS);
          fd_cnt_next    = '0;
          started_next   = 1'b0;
          state_next     = ST_DABBLE;
        end
      end
      ST_DABBLE: begin
        dab_ctrl.step = 1'b1;
        bit_cnt_next  = bit_cnt - 1'b1;
        if (bit_cnt == BIT_CNT_W'(1)) begin
          state_next = neg ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        if (out_ready) begin
          emit       = 1'b1;
          emit_code  = CHAR_MINUS;
          state_next = ST_INT;
        end
      end
      ST_INT: begin
        // leading zeros are dropped, the units digit always goes out
        if (!started && int_digit == 4'd0 && dig_cnt != DIG_CNT_W'(1)) begin
          dab_ctrl.shift_out = 1'b1;
          dig_cnt_next       = dig_cnt - 1'b1;
        end else if (out_ready) begin
          emit               = 1'b1;
          emit_code          = CHAR_ZERO + {4'd0, int_digit};
          started_next       = 1'b1;
          dab_ctrl.shift_out = 1'b1;
          dig_cnt_next       = dig_cnt - 1'b1;
          if (dig_cnt == DIG_CNT_W'(1)) begin
            state_next = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (out_ready) begin
          emit       = 1'b1;
          emit_code  = CHAR_DOT;
          state_next = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (out_ready) begin
          emit           = 1'b1;
          emit_code      = CHAR_ZERO + {4'd0, frac_digit};
          frac_ctrl.step = 1'b1;
          fd_cnt_next    = fd_cnt + 1'b1;
          if (fd_cnt == FD_CNT_W'(FRAC_DIGITS - 1)) begin
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
      started    <= 1'b0;
      bit_cnt    <= '0;
      dig_cnt    <= '0;
      fd_cnt     <= '0;
    end else begin
      state   <= state_next;
      started <= started_next;
      bit_cnt <= bit_cnt_next;
      dig_cnt <= dig_cnt_next;
      fd_cnt  <= fd_cnt_next;
      if (emit) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && value_valid) begin
      neg <= value_q16[VAL_W-1];
    end
    if (emit) begin
      char_code <= emit_code;
      last      <= emit_last;
    end
  end

endmodule

// ===== hw/rtl/fptdt_checker.sv =====
// Port-level checker for the decimal text converter, bound to the top level.
module fptdt_checker
  import fptdt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       value_valid,
  input logic       value_stall,
  input logic       char_valid,
  input logic       char_stall,
  input logic [7:0] char_code,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_code) && $stable(last))
    else $error("stalled character transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    value_valid && !value_stall |=> value_stall)
    else $error("input taken while conversion running");

  a_no_accept_mid_text: assert property (@(posedge clk) disable iff (rst)
    char_valid && !last |-> value_stall)
    else $error("input taken before text complete");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) ||
                   char_code == CHAR_MINUS || char_code == CHAR_DOT)
    else $error("illegal character code");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !char_valid && !value_stall)
    else $error("output or busy after reset");

endmodule

bind fixed_point_to_decimal_text fptdt_checker u_fptdt_checker (.*);
